// ===== rtl/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types, character codes and lookup functions for the format
// specifier parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int CH_W    = 8;
  localparam int FIELD_W = 16;
  localparam int FLAG_W  = 5;
  localparam int LEN_W   = 3;
  localparam int CONV_W  = 4;

  localparam int NUM_MAX_DEFAULT = 65535;

  // Character codes.
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_ONE   = 8'h31;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_L  = 8'h4C;
  localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CH_W-1:0] CH_C     = 8'h63;
  localparam logic [CH_W-1:0] CH_D     = 8'h64;
  localparam logic [CH_W-1:0] CH_F     = 8'h66;
  localparam logic [CH_W-1:0] CH_H     = 8'h68;
  localparam logic [CH_W-1:0] CH_I     = 8'h69;
  localparam logic [CH_W-1:0] CH_L     = 8'h6C;
  localparam logic [CH_W-1:0] CH_O     = 8'h6F;
  localparam logic [CH_W-1:0] CH_P     = 8'h70;
  localparam logic [CH_W-1:0] CH_S     = 8'h73;
  localparam logic [CH_W-1:0] CH_U     = 8'h75;
  localparam logic [CH_W-1:0] CH_X     = 8'h78;

  // Length modifier codes.
  localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
  localparam logic [LEN_W-1:0] LEN_H     = 3'd1;
  localparam logic [LEN_W-1:0] LEN_HH    = 3'd2;
  localparam logic [LEN_W-1:0] LEN_L     = 3'd3;
  localparam logic [LEN_W-1:0] LEN_LL    = 3'd4;
  localparam logic [LEN_W-1:0] LEN_BIG_L = 3'd5;
  localparam logic [LEN_W-1:0] LEN_OTHER = 3'd6;

  // Conversion type codes.
  localparam logic [CONV_W-1:0] CONV_C     = 4'd0;
  localparam logic [CONV_W-1:0] CONV_S     = 4'd1;
  localparam logic [CONV_W-1:0] CONV_P     = 4'd2;
  localparam logic [CONV_W-1:0] CONV_D     = 4'd3;
  localparam logic [CONV_W-1:0] CONV_I     = 4'd4;
  localparam logic [CONV_W-1:0] CONV_O     = 4'd5;
  localparam logic [CONV_W-1:0] CONV_U     = 4'd6;
  localparam logic [CONV_W-1:0] CONV_X     = 4'd7;
  localparam logic [CONV_W-1:0] CONV_UP_X  = 4'd8;
  localparam logic [CONV_W-1:0] CONV_F     = 4'd9;

  typedef struct packed {
    logic            spec_start;
    logic [CH_W-1:0] ch;
  } item_t;

  typedef struct packed {
    logic [FLAG_W-1:0]  flag_bits;
    logic [FIELD_W-1:0] field_width;
    logic               width_given;
    logic [FIELD_W-1:0] prec_value;
    logic               prec_given;
    logic [LEN_W-1:0]   length_mod;
    logic [CONV_W-1:0]  conv_type;
    logic               type_valid;
  } result_t;

  // One-hot flag mask for a flag character, zero for anything else.
  function automatic logic [FLAG_W-1:0] flag_mask(input logic [CH_W-1:0] c);
    logic [FLAG_W-1:0] m;
    case (c)
      CH_HASH:  m = 5'b00001;
      CH_ZERO:  m = 5'b00010;
      CH_MINUS: m = 5'b00100;
      CH_PLUS:  m = 5'b01000;
      CH_SPACE: m = 5'b10000;
      default:  m = 5'b00000;
    endcase
    return m;
  endfunction

  function automatic logic is_type(input logic [CH_W-1:0] c);
    logic t;
    case (c)
      CH_C, CH_S, CH_P, CH_D, CH_I, CH_O, CH_U, CH_X, CH_UP_X, CH_F: t = 1'b1;
      default: t = 1'b0;
    endcase
    return t;
  endfunction

  function automatic logic [CONV_W-1:0] type_code(input logic [CH_W-1:0] c);
    logic [CONV_W-1:0] t;
    case (c)
      CH_C:    t = CONV_C;
      CH_S:    t = CONV_S;
      CH_P:    t = CONV_P;
      CH_D:    t = CONV_D;
      CH_I:    t = CONV_I;
      CH_O:    t = CONV_O;
      CH_U:    t = CONV_U;
      CH_X:    t = CONV_X;
      CH_UP_X: t = CONV_UP_X;
      CH_F:    t = CONV_F;
      default: t = CONV_C;
    endcase
    return t;
  endfunction

  // Advance the length modifier code by one of 'h', 'l' or 'L'.
  function automatic logic [LEN_W-1:0] next_length(input logic [LEN_W-1:0] cur,
                                                   input logic [CH_W-1:0] c);
    logic [LEN_W-1:0] n;
    if (cur == LEN_NONE) begin
      n = (c == CH_H) ? LEN_H : ((c == CH_L) ? LEN_L : LEN_BIG_L);
    end else if (cur == LEN_H && c == CH_H) begin
      n = LEN_HH;
    end else if (cur == LEN_L && c == CH_L) begin
      n = LEN_LL;
    end else begin
      n = LEN_OTHER;
    end
    return n;
  endfunction

endpackage

// ===== rtl/fsp_input_reg.sv =====
// ----------------------------------------------------------------------------
// fsp_input_reg
// Input register stage: holds one accepted character until the parser
// takes it.
// ----------------------------------------------------------------------------
module fsp_input_reg
  import fsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  output logic  out_valid,
  output item_t out_item,
  input  logic  out_ready
);

  logic  valid;
  item_t item;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/fsp_parser.sv =====
// ----------------------------------------------------------------------------
// fsp_parser
// Parse state, one-character state update and the result register.
// ----------------------------------------------------------------------------
module fsp_parser
  import fsp_pkg::*;
#(
  parameter int NUM_MAX = NUM_MAX_DEFAULT
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  item_t   in_item,
  output logic    in_ready,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_ready
);

  localparam int ACC_W = $clog2(longint'(NUM_MAX) + 64'd1);
  localparam int PROD_W = ACC_W + 4;
  localparam logic [PROD_W-1:0] NUM_MAX_EXT = PROD_W'(NUM_MAX);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FLAGS,
    PH_WIDTH,
    PH_PREC,
    PH_LEN
  } phase_t;

  phase_t             phase, phase_next;
  logic [FLAG_W-1:0]  flags_seen, flags_seen_next;
  logic [ACC_W-1:0]   width_acc, width_acc_next;
  logic               width_flag, width_flag_next;
  logic [ACC_W-1:0]   prec_acc, prec_acc_next;
  logic               prec_flag, prec_flag_next;
  logic [LEN_W-1:0]   length_acc, length_acc_next;

  logic               res_valid;
  result_t            res;

  logic               step;
  logic               emit;
  logic [CH_W-1:0]    c;
  logic               is_digit;
  logic               is_nz_digit;
  logic               is_len;
  logic [FLAG_W-1:0]  fmask;
  logic [ACC_W-1:0]   acc_src;
  logic [PROD_W-1:0]  acc_ext;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc_new;
  logic [FIELD_W-1:0] width_out;
  logic [FIELD_W-1:0] prec_out;

  assign in_ready  = !res_valid || out_ready;
  assign step      = in_valid && in_ready;
  assign out_valid = res_valid;
  assign out_res   = res;

  assign c           = in_item.ch;
  assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_nz_digit = (c >= CH_ONE) && (c <= CH_NINE);
  assign is_len      = (c == CH_H) || (c == CH_L) || (c == CH_UP_L);
  assign fmask       = flag_mask(c);

  // One shared multiply-by-ten accumulate; the first width digit starts from zero.
  always_comb begin
    case (phase)
      PH_WIDTH: acc_src = width_acc;
      PH_PREC:  acc_src = prec_acc;
      default:  acc_src = '0;
    endcase
  end

  assign acc_ext = {4'b0000, acc_src};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(c[3:0]);
  assign acc_new = (prod > NUM_MAX_EXT) ? NUM_MAX_EXT[ACC_W-1:0] : prod[ACC_W-1:0];

  generate
    if (ACC_W > FIELD_W) begin : g_clamp
      assign width_out = (|width_acc[ACC_W-1:FIELD_W]) ? '1 : width_acc[FIELD_W-1:0];
      assign prec_out  = (|prec_acc[ACC_W-1:FIELD_W]) ? '1 : prec_acc[FIELD_W-1:0];
    end else begin : g_ext
      assign width_out = FIELD_W'(width_acc);
      assign prec_out  = FIELD_W'(prec_acc);
    end
  endgenerate

  always_comb begin
    phase_next      = phase;
    flags_seen_next = flags_seen;
    width_acc_next  = width_acc;
    width_flag_next = width_flag;
    prec_acc_next   = prec_acc;
    prec_flag_next  = prec_flag;
    length_acc_next = length_acc;
    emit            = 1'b0;
    if (in_item.spec_start) begin
      phase_next      = PH_FLAGS;
      flags_seen_next = '0;
      width_acc_next  = '0;
      width_flag_next = 1'b0;
      prec_acc_next   = '0;
      prec_flag_next  = 1'b0;
      length_acc_next = LEN_NONE;
    end else if (phase == PH_IDLE) begin
      phase_next = PH_IDLE;
    end else if (phase == PH_FLAGS && (|fmask)) begin
      flags_seen_next = flags_seen | fmask;
    end else if (phase == PH_FLAGS && is_nz_digit) begin
      width_flag_next = 1'b1;
      width_acc_next  = acc_new;
      phase_next      = PH_WIDTH;
    end else if (phase == PH_WIDTH && is_digit) begin
      width_acc_next = acc_new;
    end else if ((phase == PH_FLAGS || phase == PH_WIDTH) && c == CH_DOT) begin
      prec_flag_next = 1'b1;
      phase_next     = PH_PREC;
    end else if (phase == PH_PREC && is_digit) begin
      prec_acc_next = acc_new;
    end else if (is_len) begin
      length_acc_next = next_length(length_acc, c);
      phase_next      = PH_LEN;
    end else begin
      emit       = 1'b1;
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      flags_seen <= '0;
      width_acc  <= '0;
      width_flag <= 1'b0;
      prec_acc   <= '0;
      prec_flag  <= 1'b0;
      length_acc <= LEN_NONE;
      res_valid  <= 1'b0;
    end else begin
      if (step) begin
        phase      <= phase_next;
        flags_seen <= flags_seen_next;
        width_acc  <= width_acc_next;
        width_flag <= width_flag_next;
        prec_acc   <= prec_acc_next;
        prec_flag  <= prec_flag_next;
        length_acc <= length_acc_next;
      end
      if (step && emit) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res.flag_bits   <= flags_seen;
      res.field_width <= width_out;
      res.width_given <= width_flag;
      res.prec_value  <= prec_out;
      res.prec_given  <= prec_flag;
      res.length_mod  <= length_acc;
      res.conv_type   <= type_code(c);
      res.type_valid  <= is_type(c);
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    step && in_item.spec_start |=> phase == PH_FLAGS && flags_seen == '0
      && !width_flag && !prec_flag && length_acc == LEN_NONE)
    else $error("spec start did not open a clean spec");

  a_emit_idles: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> phase == PH_IDLE && res_valid)
    else $error("result not registered or parser not idle after a result");

  a_width_sat: assert property (@(posedge clk) disable iff (rst)
    {{4{1'b0}}, width_acc} <= NUM_MAX_EXT && {{4{1'b0}}, prec_acc} <= NUM_MAX_EXT)
    else $error("accumulator above saturation limit");

  a_width_absent: assert property (@(posedge clk) disable iff (rst)
    !width_flag |-> width_acc == '0)
    else $error("width accumulated without a width field");

  a_invalid_type: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.type_valid |-> res.conv_type == CONV_C)
    else $error("unrecognized type carries a nonzero type code");

endmodule

// ===== rtl/format_spec_parser_top.sv =====
// ----------------------------------------------------------------------------
// format_spec_parser_top
// Streaming parser for printf conversion specifiers, one character per item.
// ----------------------------------------------------------------------------
// The block takes one character per cycle and keeps up with a continuous
// stream while the master side accepts results: every cycle a new item may
// be accepted. The character that ends a spec waits in the input register
// while the parser's combinational state update computes the result, and
// once the parser takes that character it loads the finished result into
// the result register. An item with tuser set carries the leading percent
// character and opens a new spec, dropping any open one without a result.
// Flags, a width, a '.' with precision digits and a run of length modifiers
// are gathered in that order; the spec ends with exactly one result, on a
// type letter (tuser high) or on the first character that is out of order,
// NUL included (tuser low, conversion type zero). Characters outside a spec
// are dropped. Width and precision saturate at NUM_MAX and are reported
// clamped to 16 bits; absent fields report zero. Backpressure on the master
// side stalls the stream only once both the result register and the input
// register are full.
// ----------------------------------------------------------------------------
module format_spec_parser_top
  import fsp_pkg::*;
#(
  parameter int NUM_MAX = NUM_MAX_DEFAULT
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] spec_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [4:0] flag_bits, [20:5] field_width,
                                 // [21] width_given, [37:22] prec_value,
                                 // [38] prec_given, [41:39] length_mod,
                                 // [45:42] conv_type, [47:46] zero
  output logic        m_tuser    // [0] type_valid
);

  item_t   in_item;
  item_t   reg_item;
  logic    reg_valid;
  logic    reg_ready;
  result_t res;

  assign in_item.spec_start = s_tuser;
  assign in_item.ch         = s_tdata;

  // Input register stage.
  fsp_input_reg u_input_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_item   (in_item),
    .in_ready  (s_tready),
    .out_valid (reg_valid),
    .out_item  (reg_item),
    .out_ready (reg_ready)
  );

  // Parse state and result register.
  fsp_parser #(
    .NUM_MAX (NUM_MAX)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (reg_valid),
    .in_item   (reg_item),
    .in_ready  (reg_ready),
    .out_valid (m_tvalid),
    .out_res   (res),
    .out_ready (m_tready)
  );

  assign m_tdata = {2'b00, res.conv_type, res.length_mod, res.prec_given,
                    res.prec_value, res.width_given, res.field_width,
                    res.flag_bits};
  assign m_tuser = res.type_valid;

endmodule
